[sv/rws_pkg.sv]
// Shared types, constants and tables of the Ricker wavelet source.
package rws_pkg;

    // Grid and step limits
    localparam int MAX_DIM   = 1024;
    localparam int STEP_BITS = 16;
    localparam int STEP_W    = 16;
    localparam int S_W       = (STEP_BITS < STEP_W) ? STEP_BITS : STEP_W;

    // Field widths
    localparam int DT_W   = 32;
    localparam int FQ_W   = 16;
    localparam int CRD_W  = 10;
    localparam int NX_W   = 11;
    localparam int ADDR_W = 30;
    localparam int AMP_W  = 16;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // Exponential series
    localparam int EXP_TERMS   = 14;
    localparam int EXP_SQUARES = 7;
    localparam logic [33:0] PI2_Q30 = 34'd10597407032;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_TIME_DELTA     = 3'd0,
        CFG_PEAK_FREQUENCY = 3'd1,
        CFG_SOURCE_X       = 3'd2,
        CFG_SOURCE_Y       = 3'd3,
        CFG_SOURCE_Z       = 3'd4,
        CFG_WIDTH_X        = 3'd5,
        CFG_WIDTH_Z        = 3'd6
    } t_cfg_idx;

    // Register file contents
    typedef struct packed {
        logic [DT_W-1:0]  dt;
        logic [FQ_W-1:0]  freq;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] z;
        logic [NX_W-1:0]  nx;
        logic [NX_W-1:0]  nz;
    } t_cfg;

    // Series payload: current term, running sums, u in Q.24, address
    typedef struct packed {
        logic [32:0]       term;
        logic [35:0]       pos;
        logic [35:0]       neg;
        logic [32:0]       u24;
        logic [ADDR_W-1:0] addr;
    } t_exp_data;

    // Squaring payload: exponential in Q.31, |2u-1| in Q.24, sign, address
    typedef struct packed {
        logic [32:0]       e;
        logic [33:0]       mag;
        logic              negative;
        logic [ADDR_W-1:0] addr;
    } t_sq_data;

    // floor(2^36 / k) for the series divisors
    function automatic logic [36:0] recip(input logic [3:0] k);
        logic [36:0] r;
        case (k)
            4'd1:    r = 37'd68719476736;
            4'd2:    r = 37'd34359738368;
            4'd3:    r = 37'd22906492245;
            4'd4:    r = 37'd17179869184;
            4'd5:    r = 37'd13743895347;
            4'd6:    r = 37'd11453246122;
            4'd7:    r = 37'd9817068105;
            4'd8:    r = 37'd8589934592;
            4'd9:    r = 37'd7635497415;
            4'd10:   r = 37'd6871947673;
            4'd11:   r = 37'd6247225157;
            4'd12:   r = 37'd5726623061;
            4'd13:   r = 37'd5286113595;
            4'd14:   r = 37'd4908534052;
            default: r = 37'd68719476736;
        endcase
        return r;
    endfunction

endpackage

[sv/rws_front.sv]
// Front pipeline: dt*f, cutoff test, grid address and u in Q.24.
module rws_front import rws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [STEP_W-1:0] i_step,
    output logic              o_valid,
    input  logic              i_ready,
    output t_exp_data         o_data
);

    localparam int PP_W = S_W + 24;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    // Stall chain: a stage loads when empty or when its successor moves
    assign rdy6 = !r_v6 || i_ready;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Stage 1: p = dt*f, window sizes
    logic [DT_W-1:0]  d_c;
    logic [FQ_W-1:0]  f_c;
    logic [47:0]      p_c;
    logic [NX_W-1:0]  nx_c, nz_c;
    logic [21:0]      nxnz_c;
    logic [20:0]      znx_c;
    logic [S_W-1:0]   r1_s;
    logic [47:0]      r1_p;
    logic [21:0]      r1_nxnz;
    logic [20:0]      r1_znx;
    logic [CRD_W-1:0] r1_x, r1_y;

    assign d_c    = (i_cfg.dt == '0) ? DT_W'(1) : i_cfg.dt;
    assign f_c    = (i_cfg.freq == '0) ? FQ_W'(1) : i_cfg.freq;
    assign p_c    = d_c * f_c;
    assign nx_c   = (32'(i_cfg.nx) > 32'(MAX_DIM)) ? NX_W'(MAX_DIM) : i_cfg.nx;
    assign nz_c   = (32'(i_cfg.nz) > 32'(MAX_DIM)) ? NX_W'(MAX_DIM) : i_cfg.nz;
    assign nxnz_c = nx_c * nz_c;
    assign znx_c  = i_cfg.z * nx_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_s    <= i_step[S_W-1:0];
            r1_p    <= p_c;
            r1_nxnz <= nxnz_c;
            r1_znx  <= znx_c;
            r1_x    <= i_cfg.x;
            r1_y    <= i_cfg.y;
        end
    end

    // Stage 2: s*p in two partial products, flat address
    logic [PP_W-1:0]   plo_c, phi_c;
    logic [31:0]       ynz_c;
    logic [32:0]       addr_c;
    logic [PP_W-1:0]   r2_plo, r2_phi;
    logic [47:0]       r2_p;
    logic [ADDR_W-1:0] r2_addr;

    assign plo_c  = r1_s * r1_p[23:0];
    assign phi_c  = r1_s * r1_p[47:24];
    assign ynz_c  = r1_y * r1_nxnz;
    assign addr_c = 33'(ynz_c) + 33'(r1_znx) + 33'(r1_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_plo  <= plo_c;
            r2_phi  <= phi_c;
            r2_p    <= r1_p;
            r2_addr <= addr_c[ADDR_W-1:0];
        end
    end

    // Stage 3: join products, cutoff test (active while (s+1)*p <= 2^41)
    logic [63:0]       sp_c;
    logic              act_c;
    logic [41:0]       r3_sp, r3_p;
    logic [ADDR_W-1:0] r3_addr;

    assign sp_c  = 64'(r2_plo) + (64'(r2_phi) << 24);
    assign act_c = (65'(sp_c) + 65'(r2_p)) <= (65'd1 << 41);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2 && act_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_sp   <= sp_c[41:0];
            r3_p    <= r2_p[41:0];
            r3_addr <= r2_addr;
        end
    end

    // Stage 4: f*t-1 in Q.40, magnitude rounded to Q.24
    logic signed [43:0] v_c;
    logic [42:0]        m_c;
    logic [43:0]        mr_c;
    logic [26:0]        r4_m24;
    logic [ADDR_W-1:0]  r4_addr;

    assign v_c  = $signed({2'b00, r3_sp}) - $signed({2'b00, r3_p})
                - 44'sd1099511627776;
    assign m_c  = v_c[43] ? 43'(-v_c) : 43'(v_c);
    assign mr_c = {1'b0, m_c} + 44'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_m24  <= mr_c[42:16];
            r4_addr <= r3_addr;
        end
    end

    // Stage 5: square in Q.24
    logic [53:0]       sqf_c, sqr_c;
    logic [29:0]       r5_sq;
    logic [ADDR_W-1:0] r5_addr;

    assign sqf_c = r4_m24 * r4_m24;
    assign sqr_c = sqf_c + 54'd8388608;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_sq   <= sqr_c[53:24];
            r5_addr <= r4_addr;
        end
    end

    // Stage 6: u = pi^2 * sq in Q.24
    logic [63:0]       up_c, ur_c;
    logic [32:0]       r6_u24;
    logic [ADDR_W-1:0] r6_addr;

    assign up_c = r5_sq * PI2_Q30;
    assign ur_c = up_c + 64'd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (rdy6) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r6_u24  <= ur_c[62:30];
            r6_addr <= r5_addr;
        end
    end

    // Series seed: term and positive sum start at one in Q.32
    assign o_valid     = r_v6;
    assign o_data.term = 33'h1_0000_0000;
    assign o_data.pos  = 36'h1_0000_0000;
    assign o_data.neg  = '0;
    assign o_data.u24  = r6_u24;
    assign o_data.addr = r6_addr;

endmodule

[sv/rws_term.sv]
// One term of the exp(-w) series: multiply, divide by k, accumulate.
module rws_term import rws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [3:0] i_k,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_exp_data i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_exp_data o_data
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !r_v3 || i_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Stage 1: x = round(term * w / 2^32), w = 2*u24
    logic [66:0] prod_c;
    logic [63:0] sum_c;
    logic [31:0] r1_x;
    t_exp_data   r1_d;

    assign prod_c = 67'(i_data.term) * 67'({i_data.u24, 1'b0});
    assign sum_c  = prod_c[63:0] + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_x <= sum_c[63:32];
            r1_d <= i_data;
        end
    end

    // Stage 2: quotient estimate by reciprocal, at most one low
    logic [68:0] qp_c;
    logic [31:0] r2_qe, r2_x;
    t_exp_data   r2_d;

    assign qp_c = r1_x * recip(i_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_qe <= qp_c[67:36];
            r2_x  <= r1_x;
            r2_d  <= r1_d;
        end
    end

    // Stage 3: correct quotient, add to the odd or even sum
    logic [35:0] qk_c, rem_c;
    logic [31:0] q_c;
    t_exp_data   n_d3;
    t_exp_data   r3_d;

    assign qk_c  = 36'(r2_qe) * 36'(i_k);
    assign rem_c = 36'(r2_x) - qk_c;
    assign q_c   = r2_qe + 32'(rem_c >= 36'(i_k));

    always_comb begin
        n_d3      = r2_d;
        n_d3.term = 33'(q_c);
        if (i_k[0]) begin
            n_d3.neg = r2_d.neg + 36'(q_c);
        end else begin
            n_d3.pos = r2_d.pos + 36'(q_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_d <= n_d3;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r3_d;

endmodule

[sv/rws_square.sv]
// One rounded Q.31 squaring step of the exponential.
module rws_square import rws_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_sq_data i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_sq_data o_data
);

    logic     r_v;
    logic     rdy;
    logic [65:0] prod_c;
    logic [63:0] sum_c;
    t_sq_data n_d;
    t_sq_data r_d;

    assign rdy     = !r_v || i_ready;
    assign o_ready = rdy;

    // e = (e*e + 2^30) >> 31
    assign prod_c = i_data.e * i_data.e;
    assign sum_c  = prod_c[63:0] + 64'h4000_0000;

    always_comb begin
        n_d   = i_data;
        n_d.e = sum_c[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_d;

endmodule

[sv/rws_back.sv]
// Back end: finish the series, square chain, scale by 2u-1, saturate.
module rws_back import rws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_exp_data         i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_addr,
    output logic [AMP_W-1:0]  o_amp
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic sq_v   [EXP_SQUARES+1];
    logic sq_rdy [EXP_SQUARES+1];
    t_sq_data sq_d [EXP_SQUARES+1];

    assign rdy3 = !r_v3 || i_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign sq_rdy[EXP_SQUARES] = rdy2;
    assign rdy1 = !r_v1 || sq_rdy[0];
    assign o_ready = rdy1;

    // Stage 1: series difference to Q.31, |2u-1| and its sign
    logic [35:0] e_c, e1_c;
    logic [33:0] w2_c;
    logic        ge_c;
    t_sq_data    r1_d;

    assign e_c  = (i_data.pos > i_data.neg) ? i_data.pos - i_data.neg : '0;
    assign e1_c = e_c + 36'd1;
    assign w2_c = {i_data.u24, 1'b0};
    assign ge_c = w2_c >= (34'd1 << 24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_d.e        <= e1_c[33:1];
            r1_d.mag      <= ge_c ? w2_c - (34'd1 << 24) : (34'd1 << 24) - w2_c;
            r1_d.negative <= !ge_c;
            r1_d.addr     <= i_data.addr;
        end
    end

    assign sq_v[0] = r_v1;
    assign sq_d[0] = r1_d;

    // Squaring chain: exp(-u) = exp(-u/128)^128
    for (genvar g = 0; g < EXP_SQUARES; g++) begin : g_sq
        rws_square u_square (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[g]),
            .o_ready (sq_rdy[g]),
            .i_data  (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .i_ready (sq_rdy[g+1]),
            .o_data  (sq_d[g+1])
        );
    end

    // Stage 2: |2u-1| * exp(-u)
    logic [66:0]       prod_c;
    logic [66:0]       r2_prod;
    logic              r2_neg;
    logic [ADDR_W-1:0] r2_addr;

    assign prod_c = 67'(sq_d[EXP_SQUARES].mag) * 67'(sq_d[EXP_SQUARES].e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= sq_v[EXP_SQUARES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_prod <= prod_c;
            r2_neg  <= sq_d[EXP_SQUARES].negative;
            r2_addr <= sq_d[EXP_SQUARES].addr;
        end
    end

    // Stage 3: round to Q.15, apply sign, saturate (output register)
    logic [66:0]       rnd_c;
    logic [26:0]       q_c;
    logic [26:0]       nq_c;
    logic [AMP_W-1:0]  amp_c;
    logic [ADDR_W-1:0] r3_addr;
    logic [AMP_W-1:0]  r3_amp;

    assign rnd_c = r2_prod + (67'd1 << 39);
    assign q_c   = rnd_c[66:40];
    assign nq_c  = 27'd0 - q_c;

    always_comb begin
        if (r2_neg) begin
            amp_c = (q_c > 27'd32768) ? 16'h8000 : nq_c[AMP_W-1:0];
        end else begin
            amp_c = (q_c > 27'd32767) ? 16'h7fff : q_c[AMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_addr <= r2_addr;
            r3_amp  <= amp_c;
        end
    end

    assign o_valid = r_v3;
    assign o_addr  = r3_addr;
    assign o_amp   = r3_amp;

endmodule

[sv/ricker_wavelet_source_top.sv]
// Path: an accepted step passes the front pipeline, the term units and the back end to the master side.
// Throughput: one step per cycle; a stall holds every stage, bubbles collapse.
// Steps at or past the cutoff are dropped in the front pipeline, no result.
// Exp series is 14 three-stage term units, followed by 7 squaring stages.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults (dt 4294967, f 2560, source 0, windows 1024).
module ricker_wavelet_source_top import rws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Config write port
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    // Step stream
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [15:0]      i_s_axis_tdata,  // [15:0] step_index
    // Result stream
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata   // [29:0] grid_address, [45:30] amplitude
);

    // Configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dt   <= 32'd4294967;
            r_cfg.freq <= 16'd2560;
            r_cfg.x    <= '0;
            r_cfg.y    <= '0;
            r_cfg.z    <= '0;
            r_cfg.nx   <= 11'd1024;
            r_cfg.nz   <= 11'd1024;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TIME_DELTA:     r_cfg.dt   <= i_cfg_data;
                CFG_PEAK_FREQUENCY: r_cfg.freq <= i_cfg_data[FQ_W-1:0];
                CFG_SOURCE_X:       r_cfg.x    <= i_cfg_data[CRD_W-1:0];
                CFG_SOURCE_Y:       r_cfg.y    <= i_cfg_data[CRD_W-1:0];
                CFG_SOURCE_Z:       r_cfg.z    <= i_cfg_data[CRD_W-1:0];
                CFG_WIDTH_X:        r_cfg.nx   <= i_cfg_data[NX_W-1:0];
                CFG_WIDTH_Z:        r_cfg.nz   <= i_cfg_data[NX_W-1:0];
                default: ;
            endcase
        end
    end

    // Series chain links
    logic      tv   [EXP_TERMS+1];
    logic      trdy [EXP_TERMS+1];
    t_exp_data td   [EXP_TERMS+1];

    rws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_step  (i_s_axis_tdata),
        .o_valid (tv[0]),
        .i_ready (trdy[0]),
        .o_data  (td[0])
    );

    for (genvar g = 0; g < EXP_TERMS; g++) begin : g_term
        rws_term u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_k     (4'(g + 1)),
            .i_valid (tv[g]),
            .o_ready (trdy[g]),
            .i_data  (td[g]),
            .o_valid (tv[g+1]),
            .i_ready (trdy[g+1]),
            .o_data  (td[g+1])
        );
    end

    logic [ADDR_W-1:0] out_addr;
    logic [AMP_W-1:0]  out_amp;

    rws_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tv[EXP_TERMS]),
        .o_ready (trdy[EXP_TERMS]),
        .i_data  (td[EXP_TERMS]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_addr  (out_addr),
        .o_amp   (out_amp)
    );

    assign o_m_axis_tdata = {2'b00, out_amp, out_addr};

`ifndef SYNTHESIS
    // Reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // With the output stage empty every stage can move, so input is ready
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output stage empty");

    // A stalled result stays presented
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready && !i_cfg_we |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");
`endif

endmodule

[tb/tb_ricker_wavelet_source_top.sv]
// Self-checking testbench for the Ricker wavelet source: step stream in, address/amplitude out.
`timescale 1ns / 1ps
module tb_ricker_wavelet_source_top;
    import rws_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [15:0]      i_s_axis_tdata = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [47:0]      o_m_axis_tdata;

    ricker_wavelet_source_top dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [AMP_W-1:0]  amp;
    } t_wavelet_pt;

    // Shadow register file
    logic [DT_W-1:0]  sh_dt = 32'd4294967;
    logic [FQ_W-1:0]  sh_freq = 16'd2560;
    logic [CRD_W-1:0] sh_x = '0, sh_y = '0, sh_z = '0;
    logic [NX_W-1:0]  sh_nx = 11'd1024, sh_nz = 11'd1024;

    logic [15:0]  step_queue[$];
    t_wavelet_pt  wavelet_queue[$];
    int           n_errors = 0;
    int           cycle_count = 0;
    bit           quiet_phase = 1'b0;
    bit           sink_stall = 1'b1;
    bit           in_fire = 1'b0;

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // exp(-w), w Q.32, result Q.31
    function automatic logic [63:0] exp_series(input logic [63:0] w32);
        logic [63:0] term, pos, neg, e;
        term = 64'd1 << 32;
        pos = term;
        neg = 0;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * w32 + (64'd1 << 31)) >> 32) / k;
            if (k & 1) neg += term;
            else pos += term;
        end
        e = (pos > neg) ? pos - neg : 0;
        return (e + 1) >> 1;
    endfunction

    // Predict the wavelet point for one step; returns 0 when inactive
    function automatic bit predict_wavelet(input logic [15:0] step, output t_wavelet_pt pt);
        logic [63:0] d, f, p, cutoff, nx, nz, addr, m, m24, sq, u24, e, mag, q;
        logic [127:0] prod;
        longint v40;
        bit negative;
        longint amp;
        d = (sh_dt == 0) ? 1 : sh_dt;
        f = (sh_freq == 0) ? 1 : sh_freq;
        p = d * f;
        cutoff = (64'd1 << 41) / p;
        pt = '0;
        if (step >= cutoff) return 0;
        nx = (sh_nx > MAX_DIM) ? MAX_DIM : sh_nx;
        nz = (sh_nz > MAX_DIM) ? MAX_DIM : sh_nz;
        addr = sh_y * nx * nz + sh_z * nx + sh_x;
        v40 = (longint'(step) - 1) * longint'(p) - (longint'(1) << 40);
        m = (v40 < 0) ? -v40 : v40;
        m24 = (m + (64'd1 << 15)) >> 16;
        sq = (m24 * m24 + (64'd1 << 23)) >> 24;
        u24 = (sq * 64'd10597407032 + (64'd1 << 29)) >> 30;
        e = exp_series(u24 * 2);
        for (int i = 0; i < EXP_SQUARES; i++) e = (e * e + (64'd1 << 30)) >> 31;
        negative = (2 * u24 < (64'd1 << 24));
        mag = negative ? (64'd1 << 24) - 2 * u24 : 2 * u24 - (64'd1 << 24);
        prod = 128'(mag) * 128'(e);
        q = 64'((prod + (128'd1 << 39)) >> 40);
        if (negative) amp = (q > 32768) ? -32768 : -longint'(q);
        else amp = (q > 32767) ? 32767 : longint'(q);
        pt.addr = addr[ADDR_W-1:0];
        pt.amp = amp[AMP_W-1:0];
        return 1;
    endfunction

    // Driver: one step per transaction, random gaps; advance only after acceptance
    always @(negedge i_clk) begin
        if (!i_rst_n || !i_s_axis_tvalid || in_fire) begin
            if (i_rst_n && step_queue.size() > 0 &&
                (quiet_phase || $urandom_range(99) >= 26)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= step_queue.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= quiet_phase || !sink_stall || ($urandom_range(99) >= 26);
    end

    // Monitor: predict on accepted steps, check accepted results
    always @(posedge i_clk) begin
        t_wavelet_pt pt, exp_pt;
        cycle_count <= cycle_count + 1;
        in_fire <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            if (predict_wavelet(i_s_axis_tdata, pt)) wavelet_queue.push_back(pt);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (wavelet_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
            end else begin
                exp_pt = wavelet_queue.pop_front();
                if (o_m_axis_tdata[29:0] !== exp_pt.addr)
                    report_mismatch($sformatf("grid_address %h, expected %h",
                        o_m_axis_tdata[29:0], exp_pt.addr));
                if (o_m_axis_tdata[45:30] !== exp_pt.amp)
                    report_mismatch($sformatf("amplitude %h, expected %h",
                        o_m_axis_tdata[45:30], exp_pt.amp));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ricker_wavelet_source_top verification failed");
            $finish;
        end
    end

    // Wait for all steps sent, results returned, pipeline flushed
    task automatic drain_block();
        while (step_queue.size() > 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (wavelet_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TIME_DELTA:     sh_dt = val;
            CFG_PEAK_FREQUENCY: sh_freq = val[FQ_W-1:0];
            CFG_SOURCE_X:       sh_x = val[CRD_W-1:0];
            CFG_SOURCE_Y:       sh_y = val[CRD_W-1:0];
            CFG_SOURCE_Z:       sh_z = val[CRD_W-1:0];
            CFG_WIDTH_X:        sh_nx = val[NX_W-1:0];
            CFG_WIDTH_Z:        sh_nz = val[NX_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_setting(input logic [31:0] dt, input logic [15:0] f,
                                input logic [9:0] x, y, z, input logic [10:0] nx, nz);
        write_reg(CFG_TIME_DELTA, dt);
        write_reg(CFG_PEAK_FREQUENCY, 32'(f));
        write_reg(CFG_SOURCE_X, 32'(x));
        write_reg(CFG_SOURCE_Y, 32'(y));
        write_reg(CFG_SOURCE_Z, 32'(z));
        write_reg(CFG_WIDTH_X, 32'(nx));
        write_reg(CFG_WIDTH_Z, 32'(nz));
    endtask

    // Random steps mostly inside the active window of the current setting
    task automatic queue_random_steps(input int count);
        logic [63:0] cut;
        cut = (64'd1 << 41) / (((sh_dt == 0) ? 64'd1 : sh_dt) * ((sh_freq == 0) ? 1 : sh_freq));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 8 && cut > 0)
                step_queue.push_back(16'($urandom_range((cut > 65535) ? 65535 : cut - 1)));
            else
                step_queue.push_back(16'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default setting, step zero, one, peak, the cutoff and steps past it
        step_queue = '{16'd0, 16'd1, 16'd2, 16'd100, 16'd200, 16'd399, 16'd400, 16'd401,
                       16'd65535, 16'hAAAA, 16'h5555};
        drain_block();
        // Zero dt and zero frequency treated as one; wide windows clamp; largest address
        load_setting(32'd0, 16'd0, 10'd1023, 10'd1023, 10'd1023, 11'd2047, 11'd2047);
        step_queue = '{16'd0, 16'd1, 16'd5000, 16'd65535};
        drain_block();
        // Maximum dt and frequency: cutoff zero, nothing comes out
        load_setting(32'hFFFFFFFF, 16'hFFFF, 10'd0, 10'd0, 10'd0, 11'd1, 11'd1);
        step_queue = '{16'd0, 16'd1, 16'd65535};
        drain_block();
        // Coarse step, few active steps
        load_setting(32'd42949673, 16'd2560, 10'd5, 10'd7, 10'd3, 11'd16, 11'd8);
        for (int s = 0; s < 6; s++) step_queue.push_back(16'(s));
        drain_block();

        // Random phases with random settings
        for (int ph = 0; ph < 8; ph++) begin
            load_setting($urandom_range(3) == 0 ? $urandom : $urandom_range(2000000, 1),
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8000, 64)),
                10'($urandom), 10'($urandom), 10'($urandom),
                11'($urandom_range(1024, 1)), 11'($urandom_range(2047, 1)));
            quiet_phase = (ph == 3);
            sink_stall = (ph != 5);
            queue_random_steps(120);
            drain_block();
        end
        quiet_phase = 1'b0;

        if (n_errors == 0) $display("ricker_wavelet_source_top verification clean");
        else $display("ricker_wavelet_source_top verification failed");
        $finish;
    end
endmodule
